// File: rtl/wsah_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsah_pkg;

	// sample format and window
	localparam int VAL_W     = 32;
	localparam int FRAC_BITS = 16;
	localparam int WIN_LEN   = 50;
	localparam int POS_W     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;

	// running sum holds WIN_LEN full-scale samples
	localparam int SUM_W = VAL_W + $clog2(WIN_LEN);

	// shared divider width: covers 2 << 2F and the window denominator with headroom
	localparam int DIV_W = 2 * FRAC_BITS + 3;
	localparam int CNT_W = $clog2(DIV_W + 1);

	// display modes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAW     = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NOLOAD_LEVEL = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/wsah_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsah_sample_if import wsah_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] sample_mv;
	logic                    no_data;

	modport source (output valid, output sample_mv, output no_data, input ready);
	modport sink   (input valid, input sample_mv, input no_data, output ready);
endinterface

`default_nettype wire

// File: rtl/wsah_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsah_result_if import wsah_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] shown_value;
	logic signed [VAL_W-1:0] average_value;
	logic signed [VAL_W-1:0] window_width;

	modport source (output valid, output shown_value, output average_value,
		output window_width, input ready);
	modport sink   (input valid, input shown_value, input average_value,
		input window_width, output ready);
endinterface

`default_nettype wire

// File: rtl/wsah_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsah_cfg_if import wsah_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VAL_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/wsah_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wsah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/wsah_div.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module wsah_div import wsah_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             take;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		take  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/weigh_sample_average_hold_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sequence: a no-data sample outside hold mode goes from accept through the hold and output
//   steps; hold mode adds up to two divisions, reciprocal then window width, and a compare step
// intake: one request at a time, the next taken only once back in idle, which comes
//   later while the result register waits on the receiver
// reset: arst_n clears the sum, write position, average, held value, registers and
//   window valid bits at once; no clearing pass, empty window entries read as zero
module weigh_sample_average_hold_unit import wsah_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	wsah_sample_if.sink    samples,
	wsah_result_if.source  results,
	wsah_cfg_if.sink       cfg_write
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_HOLD,
		ST_RECIP_WAIT,
		ST_DEN_CHK,
		ST_WIDTH_WAIT,
		ST_COMPARE,
		ST_OUT
	} state_t;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [DIV_W-1:0] ONE_2F = DIV_W'(1) << (2 * FRAC_BITS);
	localparam logic [DIV_W-1:0] TWO_2F = DIV_W'(1) << (2 * FRAC_BITS + 1);
	localparam logic signed [DIV_W:0] SIX_F = (DIV_W + 1)'(6) << FRAC_BITS;

	// average as |sum| * ceil(2^AVG_SHIFT / WIN_LEN) >> AVG_SHIFT, exact over the sum range;
	// the constant is applied in two halves on one multiplier
	localparam int AVG_SHIFT = SUM_W - 1 + POS_W;
	localparam logic [63:0] AVG_RECIP =
		((64'd1 << AVG_SHIFT) + 64'(WIN_LEN - 1)) / 64'(WIN_LEN);
	localparam int RCP_W     = AVG_SHIFT - $clog2(WIN_LEN) + 1;
	localparam int RCP_SPLIT = (RCP_W + 1) / 2;
	localparam int PROD_W    = SUM_W + RCP_SPLIT;
	localparam logic [RCP_SPLIT-1:0] RCP_LO = AVG_RECIP[RCP_SPLIT-1:0];
	localparam logic [RCP_SPLIT-1:0] RCP_HI = AVG_RECIP[RCP_SPLIT +: RCP_SPLIT];

	state_t state_q;

	// configuration registers
	logic        [MODE_W-1:0] mode_q;
	logic signed [VAL_W-1:0]  noload_q;

	// architectural state
	logic signed [SUM_W-1:0] sum_q;
	logic        [POS_W-1:0] pos_q;
	logic signed [VAL_W-1:0] avg_q;
	logic signed [VAL_W-1:0] held_q;
	logic                    ent_valid_q [WIN_LEN];

	// per request working registers
	logic signed [VAL_W-1:0] smp_q;
	logic                    d_neg_q;
	logic signed [DIV_W:0]   den_q;
	logic signed [VAL_W-1:0] w_q;
	logic        [SUM_W-1:0] avg_lo_q;

	// result register
	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_shown_q;
	logic signed [VAL_W-1:0] res_avg_q;
	logic signed [VAL_W-1:0] res_w_q;

	logic             accept;
	logic [VAL_W-1:0] ram_rdata;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic signed [VAL_W-1:0] old_smp;
	logic        [SUM_W-1:0] sum_abs;
	logic [RCP_SPLIT-1:0]    avg_factor;
	logic [PROD_W-1:0]       avg_prod;
	logic [PROD_W-1:0]       avg_acc;
	logic signed [VAL_W:0]   d_val;
	logic        [VAL_W:0]   d_abs;
	logic        [DIV_W:0]   den_abs;
	logic signed [DIV_W:0]   quo_ext;
	logic signed [DIV_W:0]   recip;
	logic signed [DIV_W:0]   w_wide;
	logic signed [VAL_W-1:0] w_sat;
	logic        [VAL_W-1:0] avg_mag;
	logic signed [VAL_W-1:0] avg_new;
	logic signed [VAL_W+1:0] diff;
	logic signed [VAL_W+1:0] diff_abs;
	logic [POS_W-1:0]        pos_next;

	assign samples.ready   = (state_q == ST_IDLE);
	assign accept          = samples.valid && samples.ready;
	assign cfg_write.ready = 1'b1;

	assign results.valid         = res_valid_q;
	assign results.shown_value   = res_shown_q;
	assign results.average_value = res_avg_q;
	assign results.window_width  = res_w_q;

	// sample window store, oldest entry fetched when a valid sample is taken
	wsah_ram #(
		.WIDTH (VAL_W),
		.DEPTH (WIN_LEN)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (pos_q),
		.wdata (smp_q),
		.re    (accept && !samples.no_data),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	wsah_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		// never written entries read as zero
		old_smp  = ent_valid_q[pos_q] ? $signed(ram_rdata) : '0;
		pos_next = (pos_q == POS_W'(WIN_LEN - 1)) ? '0 : pos_q + POS_W'(1);

		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

		// low half of the reciprocal first, then high half plus the carried low product
		avg_factor = (state_q == ST_AVG_GO) ? RCP_LO : RCP_HI;
		avg_prod   = PROD_W'(sum_abs) * PROD_W'(avg_factor);
		avg_acc    = avg_prod + PROD_W'(avg_lo_q);

		// distance of held value from tare, exact in one extra bit
		d_val = (VAL_W + 1)'(held_q) - (VAL_W + 1)'(noload_q);
		d_abs = d_val[VAL_W] ? (VAL_W + 1)'(-d_val) : (VAL_W + 1)'(d_val);

		den_abs = den_q[DIV_W] ? (DIV_W + 1)'(-den_q) : (DIV_W + 1)'(den_q);

		// signed quotients, truncated toward zero
		quo_ext = $signed({1'b0, div_rsp.quotient});
		recip   = d_neg_q ? -quo_ext : quo_ext;
		w_wide  = den_q[DIV_W] ? -quo_ext : quo_ext;
		if (w_wide > (DIV_W + 1)'(VAL_MAX)) begin
			w_sat = VAL_MAX;
		end else if (w_wide < (DIV_W + 1)'(VAL_MIN)) begin
			w_sat = VAL_MIN;
		end else begin
			w_sat = w_wide[VAL_W-1:0];
		end

		avg_mag = avg_acc[AVG_SHIFT - RCP_SPLIT +: VAL_W];
		avg_new = sum_q[SUM_W-1] ? $signed(-avg_mag) : $signed(avg_mag);

		diff     = (VAL_W + 2)'(avg_q) - (VAL_W + 2)'(held_q);
		diff_abs = diff[VAL_W+1] ? -diff : diff;

		// shared divider request by sequencer step
		div_req.start    = 1'b0;
		div_req.dividend = ONE_2F;
		div_req.divisor  = den_abs[DIV_W-1:0];
		case (state_q)
			ST_HOLD: begin
				div_req.start    = (mode_q == MODE_HOLD) && (d_val != '0);
				div_req.dividend = TWO_2F;
				div_req.divisor  = DIV_W'(d_abs);
			end
			ST_DEN_CHK: begin
				div_req.start = (den_q != '0);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_HOLD;
			noload_q    <= '0;
			sum_q       <= '0;
			pos_q       <= '0;
			avg_q       <= '0;
			held_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < WIN_LEN; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else begin
			// register writes, to be issued only while idle; the block itself does not enforce this
			if (cfg_write.valid) begin
				case (cfg_write.index)
					REG_DISPLAY_MODE: mode_q   <= cfg_write.data[MODE_W-1:0];
					REG_NOLOAD_LEVEL: noload_q <= $signed(cfg_write.data);
					default: ;
				endcase
			end

			// result taken, unless the output step loads the next one
			if (results.ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= samples.no_data ? ST_HOLD : ST_READ;
					end
				end
				ST_READ: begin
					// replace the oldest entry and keep the running sum
					sum_q <= sum_q + SUM_W'(smp_q) - SUM_W'(old_smp);
					ent_valid_q[pos_q] <= 1'b1;
					pos_q   <= pos_next;
					state_q <= ST_AVG_GO;
				end
				ST_AVG_GO: begin
					state_q <= ST_AVG_WAIT;
				end
				ST_AVG_WAIT: begin
					avg_q   <= avg_new;
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					case (mode_q)
						MODE_HOLD: begin
							// held equal to tare gives a zero window
							if (d_val == '0) begin
								state_q <= ST_COMPARE;
							end else begin
								state_q <= ST_RECIP_WAIT;
							end
						end
						MODE_AVERAGE: begin
							held_q  <= avg_q;
							state_q <= ST_OUT;
						end
						MODE_RAW: begin
							held_q  <= smp_q;
							state_q <= ST_OUT;
						end
						default: begin
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_RECIP_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_DEN_CHK;
					end
				end
				ST_DEN_CHK: begin
					// zero denominator saturates the window
					state_q <= (den_q == '0) ? ST_COMPARE : ST_WIDTH_WAIT;
				end
				ST_WIDTH_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_COMPARE;
					end
				end
				ST_COMPARE: begin
					// a negative window always lets the held value follow
					if (diff_abs > (VAL_W + 2)'(w_q)) begin
						held_q <= avg_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || results.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working and result payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					smp_q <= samples.sample_mv;
				end
				w_q <= '0;
			end
			ST_AVG_GO: begin
				avg_lo_q <= avg_prod[RCP_SPLIT +: SUM_W];
			end
			ST_HOLD: begin
				d_neg_q <= d_val[VAL_W];
				w_q     <= '0;
			end
			ST_RECIP_WAIT: begin
				if (div_rsp.done) begin
					den_q <= SIX_F + recip;
				end
			end
			ST_DEN_CHK: begin
				if (den_q == '0) begin
					w_q <= VAL_MAX;
				end
			end
			ST_WIDTH_WAIT: begin
				if (div_rsp.done) begin
					w_q <= w_sat;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || results.ready) begin
					res_shown_q <= held_q;
					res_avg_q   <= avg_q;
					res_w_q     <= w_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
